// File: sv/edge_table_with_adjacency_defines.svh
// ----------------------------------------------------------------------------
// edge_table_with_adjacency_defines
// assertion macros shared by the block
// ----------------------------------------------------------------------------
`ifndef EDGE_TABLE_WITH_ADJACENCY_DEFINES_SVH
`define EDGE_TABLE_WITH_ADJACENCY_DEFINES_SVH

// condition holds in the same cycle
`define ETWA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the next cycle
`define ETWA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/etwa_pkg.sv
// ----------------------------------------------------------------------------
// etwa_pkg
// shared sizes, codes and types of the edge table with adjacency lists
// ----------------------------------------------------------------------------
package etwa_pkg;

    localparam int MAX_VERTICES = 256;
    localparam int MAX_EDGES    = 1024;
    localparam int MAX_DEGREE   = 16;

    localparam int VW  = $clog2(MAX_VERTICES);
    localparam int VCW = $clog2(MAX_VERTICES + 1);
    localparam int EW  = $clog2(MAX_EDGES);
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int LW  = $clog2(MAX_DEGREE + 1);
    localparam int IW  = $clog2(MAX_VERTICES * MAX_DEGREE);

    localparam int CMDW  = 2;
    localparam int EPW   = 16;
    localparam int SLOTW = 10;
    localparam int STW   = 3;
    localparam int ETW   = 11;
    localparam int VTW   = 9;
    localparam int NIW   = 10;

    typedef enum logic [CMDW-1:0] {
        CMD_ADD_EDGE = 2'd0,
        CMD_REM_EDGE = 2'd1,
        CMD_ADD_VTX  = 2'd2,
        CMD_CLEAR    = 2'd3
    } cmd_t;

    typedef enum logic [STW-1:0] {
        ST_OK        = 3'd0,
        ST_RANGE     = 3'd1,
        ST_EDGE_FULL = 3'd2,
        ST_ADJ_FULL  = 3'd3,
        ST_VTX_FULL  = 3'd4
    } status_t;

    typedef struct packed {
        logic [CMDW-1:0]  cmd;
        logic [EPW-1:0]   endpoint_a;
        logic [EPW-1:0]   endpoint_b;
        logic [SLOTW-1:0] edge_slot;
    } item_t;

    typedef struct packed {
        logic [STW-1:0] status;
        logic [ETW-1:0] edge_total;
        logic [VTW-1:0] vertex_total;
        logic [NIW-1:0] new_index;
    } result_t;

    typedef struct packed {
        logic idle;
        logic done;
    } ctl_t;

    // flat address of entry i in the list of vertex v
    function automatic logic [IW-1:0] inc_addr(input logic [VW-1:0] v,
                                               input logic [LW-1:0] i);
        inc_addr = IW'(v) * IW'(MAX_DEGREE) + IW'(i);
    endfunction

endpackage

// File: sv/etwa_ram.sv
// ----------------------------------------------------------------------------
// etwa_ram
// generic simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module etwa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/etwa_seq.sv
// ----------------------------------------------------------------------------
// etwa_seq
// command sequencer: edge table, list lengths, list store and the scan compare
// ----------------------------------------------------------------------------
module etwa_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  etwa_pkg::item_t   item,
    input  logic              res_ready,
    output etwa_pkg::ctl_t    ctl,
    output etwa_pkg::result_t res
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_RA,
        S_ADD_RB,
        S_ADD_CHK,
        S_ADD_PB,
        S_RM_P0,
        S_RM_P1,
        S_RM_P2,
        S_RM_DISP,
        S_L_LEN,
        S_L_N,
        S_L_SCAN,
        S_L_DEL,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        PH_DEL_A,
        PH_DEL_B,
        PH_MOVE,
        PH_REW_A,
        PH_REW_B,
        PH_END
    } phase_t;

    localparam int PW = 2 * etwa_pkg::EPW;

    state_t                        state_reg, state_next;
    phase_t                        phase_reg, phase_next;
    etwa_pkg::item_t               item_reg, item_next;
    logic [etwa_pkg::ECW-1:0]      ecnt_reg, ecnt_next;
    logic [etwa_pkg::VCW-1:0]      vcnt_reg, vcnt_next;
    logic [etwa_pkg::MAX_VERTICES-1:0] vld_reg, vld_next;
    logic                          lvld_reg;
    logic [etwa_pkg::LW-1:0]       la_reg, la_next;
    logic [etwa_pkg::LW-1:0]       lb_reg, lb_next;
    logic [PW-1:0]                 pr_reg, pr_next;
    logic [PW-1:0]                 pl_reg, pl_next;
    logic [etwa_pkg::VW-1:0]       opv_reg, opv_next;
    logic                          opdel_reg, opdel_next;
    logic [etwa_pkg::LW-1:0]       n_reg, n_next;
    logic [etwa_pkg::LW-1:0]       idx_reg, idx_next;
    logic                          pend_reg, pend_next;
    logic [etwa_pkg::LW-1:0]       cidx_reg, cidx_next;
    logic [etwa_pkg::LW-1:0]       hit_reg, hit_next;
    etwa_pkg::status_t             st_reg, st_next;
    logic [etwa_pkg::NIW-1:0]      ni_reg, ni_next;

    logic                          edge_we;
    logic [etwa_pkg::EW-1:0]       edge_waddr, edge_raddr;
    logic [PW-1:0]                 edge_wdata, edge_rdata;
    logic                          len_we;
    logic [etwa_pkg::VW-1:0]       len_waddr, len_raddr;
    logic [etwa_pkg::LW-1:0]       len_wdata, len_rdata;
    logic                          inc_we;
    logic [etwa_pkg::IW-1:0]       inc_waddr, inc_raddr;
    logic [etwa_pkg::EW-1:0]       inc_wdata, inc_rdata;

    logic [etwa_pkg::EPW-1:0]      ea, eb, ra, rb, sa, sb;
    logic                          rec_a, rec_b, rec_ra, rec_rb, rec_sa, rec_sb;
    logic [etwa_pkg::EW-1:0]       slot, last, tgt;
    logic                          moving;
    logic [etwa_pkg::LW-1:0]       len_q;

    etwa_ram #(.WIDTH(PW), .DEPTH(etwa_pkg::MAX_EDGES)) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (edge_waddr),
        .wdata (edge_wdata),
        .raddr (edge_raddr),
        .rdata (edge_rdata)
    );

    etwa_ram #(.WIDTH(etwa_pkg::LW), .DEPTH(etwa_pkg::MAX_VERTICES)) u_len_ram (
        .clk   (clk),
        .we    (len_we),
        .waddr (len_waddr),
        .wdata (len_wdata),
        .raddr (len_raddr),
        .rdata (len_rdata)
    );

    etwa_ram #(
        .WIDTH (etwa_pkg::EW),
        .DEPTH (etwa_pkg::MAX_VERTICES * etwa_pkg::MAX_DEGREE)
    ) u_inc_ram (
        .clk   (clk),
        .we    (inc_we),
        .waddr (inc_waddr),
        .wdata (inc_wdata),
        .raddr (inc_raddr),
        .rdata (inc_rdata)
    );

    assign ea     = item_reg.endpoint_a;
    assign eb     = item_reg.endpoint_b;
    assign ra     = pr_reg[PW-1:etwa_pkg::EPW];
    assign rb     = pr_reg[etwa_pkg::EPW-1:0];
    assign sa     = pl_reg[PW-1:etwa_pkg::EPW];
    assign sb     = pl_reg[etwa_pkg::EPW-1:0];
    assign rec_a  = ea < etwa_pkg::EPW'(vcnt_reg);
    assign rec_b  = (eb < etwa_pkg::EPW'(vcnt_reg)) && (eb != ea);
    assign rec_ra = ra < etwa_pkg::EPW'(vcnt_reg);
    assign rec_rb = (rb < etwa_pkg::EPW'(vcnt_reg)) && (rb != ra);
    assign rec_sa = sa < etwa_pkg::EPW'(vcnt_reg);
    assign rec_sb = (sb < etwa_pkg::EPW'(vcnt_reg)) && (sb != sa);
    assign slot   = etwa_pkg::EW'(item_reg.edge_slot);
    assign last   = etwa_pkg::EW'(ecnt_reg - etwa_pkg::ECW'(1));
    assign moving = slot != last;
    assign tgt    = opdel_reg ? slot : last;
    // a length never written since reset, clear or vertex add reads as empty
    assign len_q  = lvld_reg ? len_rdata : '0;

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        item_next  = item_reg;
        ecnt_next  = ecnt_reg;
        vcnt_next  = vcnt_reg;
        vld_next   = vld_reg;
        la_next    = la_reg;
        lb_next    = lb_reg;
        pr_next    = pr_reg;
        pl_next    = pl_reg;
        opv_next   = opv_reg;
        opdel_next = opdel_reg;
        n_next     = n_reg;
        idx_next   = idx_reg;
        pend_next  = pend_reg;
        cidx_next  = cidx_reg;
        hit_next   = hit_reg;
        st_next    = st_reg;
        ni_next    = ni_reg;

        edge_we    = 1'b0;
        edge_waddr = slot;
        edge_wdata = pl_reg;
        edge_raddr = slot;
        len_we     = 1'b0;
        len_waddr  = opv_reg;
        len_wdata  = n_reg - etwa_pkg::LW'(1);
        len_raddr  = opv_reg;
        inc_we     = 1'b0;
        inc_waddr  = etwa_pkg::inc_addr(opv_reg, hit_reg);
        inc_wdata  = inc_rdata;
        inc_raddr  = etwa_pkg::inc_addr(opv_reg, idx_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    item_next = item;
                    st_next   = etwa_pkg::ST_OK;
                    ni_next   = '0;
                    unique case (etwa_pkg::cmd_t'(item.cmd))
                        etwa_pkg::CMD_ADD_EDGE:
                        begin
                            state_next = S_ADD_RA;
                        end
                        etwa_pkg::CMD_REM_EDGE:
                        begin
                            if (etwa_pkg::ECW'(item.edge_slot) >= ecnt_reg)
                            begin
                                st_next    = etwa_pkg::ST_RANGE;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_RM_P0;
                            end
                        end
                        etwa_pkg::CMD_ADD_VTX:
                        begin
                            if (vcnt_reg == etwa_pkg::VCW'(etwa_pkg::MAX_VERTICES))
                            begin
                                st_next = etwa_pkg::ST_VTX_FULL;
                            end
                            else
                            begin
                                ni_next = etwa_pkg::NIW'(vcnt_reg);
                                vld_next[etwa_pkg::VW'(vcnt_reg)] = 1'b0;
                                vcnt_next = vcnt_reg + etwa_pkg::VCW'(1);
                            end
                            state_next = S_DONE;
                        end
                        etwa_pkg::CMD_CLEAR:
                        begin
                            ecnt_next  = '0;
                            vcnt_next  = '0;
                            vld_next   = '0;
                            state_next = S_DONE;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_ADD_RA:
            begin
                len_raddr  = etwa_pkg::VW'(ea);
                state_next = S_ADD_RB;
            end
            S_ADD_RB:
            begin
                la_next    = len_q;
                len_raddr  = etwa_pkg::VW'(eb);
                state_next = S_ADD_CHK;
            end
            S_ADD_CHK:
            begin
                lb_next    = len_q;
                state_next = S_DONE;
                if (ecnt_reg == etwa_pkg::ECW'(etwa_pkg::MAX_EDGES))
                begin
                    st_next = etwa_pkg::ST_EDGE_FULL;
                end
                else if ((rec_a && la_reg == etwa_pkg::LW'(etwa_pkg::MAX_DEGREE)) ||
                         (rec_b && len_q == etwa_pkg::LW'(etwa_pkg::MAX_DEGREE)))
                begin
                    st_next = etwa_pkg::ST_ADJ_FULL;
                end
                else
                begin
                    edge_we    = 1'b1;
                    edge_waddr = etwa_pkg::EW'(ecnt_reg);
                    edge_wdata = {ea, eb};
                    ecnt_next  = ecnt_reg + etwa_pkg::ECW'(1);
                    ni_next    = etwa_pkg::NIW'(ecnt_reg);
                    if (rec_a)
                    begin
                        inc_we    = 1'b1;
                        inc_waddr = etwa_pkg::inc_addr(etwa_pkg::VW'(ea), la_reg);
                        inc_wdata = etwa_pkg::EW'(ecnt_reg);
                        len_we    = 1'b1;
                        len_waddr = etwa_pkg::VW'(ea);
                        len_wdata = la_reg + etwa_pkg::LW'(1);
                        vld_next[etwa_pkg::VW'(ea)] = 1'b1;
                    end
                    state_next = S_ADD_PB;
                end
            end
            S_ADD_PB:
            begin
                if (rec_b)
                begin
                    inc_we    = 1'b1;
                    inc_waddr = etwa_pkg::inc_addr(etwa_pkg::VW'(eb), lb_reg);
                    inc_wdata = etwa_pkg::EW'(ni_reg);
                    len_we    = 1'b1;
                    len_waddr = etwa_pkg::VW'(eb);
                    len_wdata = lb_reg + etwa_pkg::LW'(1);
                    vld_next[etwa_pkg::VW'(eb)] = 1'b1;
                end
                state_next = S_DONE;
            end
            S_RM_P0:
            begin
                edge_raddr = slot;
                state_next = S_RM_P1;
            end
            S_RM_P1:
            begin
                pr_next    = edge_rdata;
                edge_raddr = last;
                state_next = S_RM_P2;
            end
            S_RM_P2:
            begin
                pl_next    = edge_rdata;
                phase_next = PH_DEL_A;
                state_next = S_RM_DISP;
            end
            S_RM_DISP:
            begin
                unique case (phase_reg)
                    PH_DEL_A:
                    begin
                        phase_next = PH_DEL_B;
                        if (rec_ra)
                        begin
                            opv_next   = etwa_pkg::VW'(ra);
                            opdel_next = 1'b1;
                            state_next = S_L_LEN;
                        end
                    end
                    PH_DEL_B:
                    begin
                        phase_next = PH_MOVE;
                        if (rec_rb)
                        begin
                            opv_next   = etwa_pkg::VW'(rb);
                            opdel_next = 1'b1;
                            state_next = S_L_LEN;
                        end
                    end
                    PH_MOVE:
                    begin
                        phase_next = PH_REW_A;
                        if (moving)
                        begin
                            edge_we = 1'b1;
                        end
                    end
                    PH_REW_A:
                    begin
                        phase_next = PH_REW_B;
                        if (moving && rec_sa)
                        begin
                            opv_next   = etwa_pkg::VW'(sa);
                            opdel_next = 1'b0;
                            state_next = S_L_LEN;
                        end
                    end
                    PH_REW_B:
                    begin
                        phase_next = PH_END;
                        if (moving && rec_sb)
                        begin
                            opv_next   = etwa_pkg::VW'(sb);
                            opdel_next = 1'b0;
                            state_next = S_L_LEN;
                        end
                    end
                    default:
                    begin
                        ecnt_next  = ecnt_reg - etwa_pkg::ECW'(1);
                        state_next = S_DONE;
                    end
                endcase
            end
            S_L_LEN:
            begin
                len_raddr  = opv_reg;
                state_next = S_L_N;
            end
            S_L_N:
            begin
                n_next     = len_q;
                idx_next   = '0;
                pend_next  = 1'b0;
                state_next = S_L_SCAN;
            end
            S_L_SCAN:
            begin
                // one read issued per cycle, compared against the target in the next cycle
                if (pend_reg && inc_rdata == tgt)
                begin
                    if (opdel_reg)
                    begin
                        inc_raddr  = etwa_pkg::inc_addr(opv_reg, n_reg - etwa_pkg::LW'(1));
                        hit_next   = cidx_reg;
                        state_next = S_L_DEL;
                    end
                    else
                    begin
                        inc_we     = 1'b1;
                        inc_waddr  = etwa_pkg::inc_addr(opv_reg, cidx_reg);
                        inc_wdata  = slot;
                        state_next = S_RM_DISP;
                    end
                end
                else if (idx_reg >= n_reg && !pend_reg)
                begin
                    state_next = S_RM_DISP;
                end
                else
                begin
                    pend_next = idx_reg < n_reg;
                    cidx_next = idx_reg;
                    if (idx_reg < n_reg)
                    begin
                        idx_next = idx_reg + etwa_pkg::LW'(1);
                    end
                end
            end
            S_L_DEL:
            begin
                // last entry moves into the freed place
                inc_we     = 1'b1;
                inc_waddr  = etwa_pkg::inc_addr(opv_reg, hit_reg);
                inc_wdata  = inc_rdata;
                len_we     = 1'b1;
                len_waddr  = opv_reg;
                len_wdata  = n_reg - etwa_pkg::LW'(1);
                vld_next[opv_reg] = 1'b1;
                state_next = S_RM_DISP;
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_DEL_A;
            ecnt_reg  <= '0;
            vcnt_reg  <= '0;
            vld_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            ecnt_reg  <= ecnt_next;
            vcnt_reg  <= vcnt_next;
            vld_reg   <= vld_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lvld_reg  <= vld_reg[len_raddr];
        item_reg  <= item_next;
        la_reg    <= la_next;
        lb_reg    <= lb_next;
        pr_reg    <= pr_next;
        pl_reg    <= pl_next;
        opv_reg   <= opv_next;
        opdel_reg <= opdel_next;
        n_reg     <= n_next;
        idx_reg   <= idx_next;
        cidx_reg  <= cidx_next;
        hit_reg   <= hit_next;
        st_reg    <= st_next;
        ni_reg    <= ni_next;
    end

    assign ctl.idle         = state_reg == S_IDLE;
    assign ctl.done         = state_reg == S_DONE;
    assign res.status       = st_reg;
    assign res.edge_total   = etwa_pkg::ETW'(ecnt_reg);
    assign res.vertex_total = etwa_pkg::VTW'(vcnt_reg);
    assign res.new_index    = ni_reg;

endmodule

// File: sv/edge_table_with_adjacency.sv
// ----------------------------------------------------------------------------
// edge_table_with_adjacency
// dense edge table with per-vertex incidence lists, one result per command
// ----------------------------------------------------------------------------
// input channel: in_valid/in_stall with cmd, endpoint_a, endpoint_b, edge_slot
// output channel: out_valid/out_stall with status, edge_total, vertex_total,
// new_index; exactly one result item per input item, in order
// one item at a time: in_stall is high from the cycle after an accept until
// the result has moved into the output register
// a remove scans each incidence list that it touches (up to four); the scan
// reads one entry per cycle through the single read port of the incidence
// memory; the next item may be taken in the same cycle as out_valid rises
// reset clears both counts and all list lengths at once through per-vertex
// valid bits; no clearing pass is needed and the block is ready right away
// while out_stall holds, the result waits in the output register; the next
// item is still accepted and runs until its own result is ready
module edge_table_with_adjacency (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [etwa_pkg::CMDW-1:0]  cmd,
    input  logic [etwa_pkg::EPW-1:0]   endpoint_a,
    input  logic [etwa_pkg::EPW-1:0]   endpoint_b,
    input  logic [etwa_pkg::SLOTW-1:0] edge_slot,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [etwa_pkg::STW-1:0]   status,
    output logic [etwa_pkg::ETW-1:0]   edge_total,
    output logic [etwa_pkg::VTW-1:0]   vertex_total,
    output logic [etwa_pkg::NIW-1:0]   new_index
);

`include "edge_table_with_adjacency_defines.svh"

    etwa_pkg::item_t   item;
    etwa_pkg::ctl_t    ctl;
    etwa_pkg::result_t res;
    etwa_pkg::result_t res_reg;
    logic              out_valid_reg, out_valid_next;
    logic              start;
    logic              res_ready;

    assign item.cmd        = cmd;
    assign item.endpoint_a = endpoint_a;
    assign item.endpoint_b = endpoint_b;
    assign item.edge_slot  = edge_slot;

    assign in_stall  = !ctl.idle;
    assign start     = in_valid && ctl.idle;
    assign res_ready = !out_valid_reg || !out_stall;

    etwa_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .res_ready (res_ready),
        .ctl       (ctl),
        .res       (res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.done && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.done && res_ready)
        begin
            res_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = res_reg.status;
    assign edge_total   = res_reg.edge_total;
    assign vertex_total = res_reg.vertex_total;
    assign new_index    = res_reg.new_index;

    `ETWA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall,
        "block took a second item while busy")
    `ETWA_ASSERT_NOW(a_edge_bound, out_valid,
        edge_total <= etwa_pkg::ETW'(etwa_pkg::MAX_EDGES), "edge count beyond table size")
    `ETWA_ASSERT_NOW(a_refused_index, out_valid && status != etwa_pkg::ST_OK,
        new_index == '0, "refused command reports an index")

endmodule

// File: verif/edge_table_with_adjacency_tb.sv
// ----------------------------------------------------------------------------
// edge_table_with_adjacency_tb
// self-checking bench for the edge table with per-vertex incidence lists
// ----------------------------------------------------------------------------
// short directed table first, then one adjacency list, the vertex table and
// the edge table are filled to their limits, with a long result-side stall
// in between; a random mix of graph edits runs last; every result is checked
// against a row's own expected values, else a model of the tables in the bench
module edge_table_with_adjacency_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_LIMIT = 2000000;
    localparam int SETTLE    = 100;

    typedef struct {
        etwa_pkg::item_t   it;
        bit                chk;
        etwa_pkg::result_t res;
    } row_t;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic [etwa_pkg::CMDW-1:0]     cmd;
    logic [etwa_pkg::EPW-1:0]      endpoint_a;
    logic [etwa_pkg::EPW-1:0]      endpoint_b;
    logic [etwa_pkg::SLOTW-1:0]    edge_slot;
    logic                          out_valid;
    logic                          out_stall;
    logic [etwa_pkg::STW-1:0]      status;
    logic [etwa_pkg::ETW-1:0]      edge_total;
    logic [etwa_pkg::VTW-1:0]      vertex_total;
    logic [etwa_pkg::NIW-1:0]      new_index;

    edge_table_with_adjacency uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .endpoint_a(endpoint_a), .endpoint_b(endpoint_b),
        .edge_slot(edge_slot),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .edge_total(edge_total),
        .vertex_total(vertex_total), .new_index(new_index)
    );

    // graph mirror
    logic [31:0]             pair_tab [etwa_pkg::MAX_EDGES];
    logic [etwa_pkg::EW-1:0] inc_tab [etwa_pkg::MAX_VERTICES*etwa_pkg::MAX_DEGREE];
    int                      inc_len [etwa_pkg::MAX_VERTICES];
    int                      n_edges;
    int                      n_verts;

    etwa_pkg::result_t want_q[$];
    row_t              sent_q[$];
    row_t              dir_tab[$];

    int  mismatches;
    int  n_taken;
    int  n_seen;
    int  status_seen [8];
    int  cycles;
    bit  idle_on;
    bit  long_req;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic void drop_index(int v, int e);
        int n;
        n = inc_len[v];
        for (int i = 0; i < n; i++)
        begin
            if (inc_tab[v*etwa_pkg::MAX_DEGREE+i] == etwa_pkg::EW'(e))
            begin
                inc_tab[v*etwa_pkg::MAX_DEGREE+i] = inc_tab[v*etwa_pkg::MAX_DEGREE+n-1];
                inc_len[v] = n - 1;
                return;
            end
        end
    endfunction

    function automatic void move_index(int v, int from, int to);
        for (int i = 0; i < inc_len[v]; i++)
        begin
            if (inc_tab[v*etwa_pkg::MAX_DEGREE+i] == etwa_pkg::EW'(from))
            begin
                inc_tab[v*etwa_pkg::MAX_DEGREE+i] = etwa_pkg::EW'(to);
                return;
            end
        end
    endfunction

    function automatic etwa_pkg::result_t apply_command(etwa_pkg::item_t it);
        etwa_pkg::result_t r;
        int a, b, s, ra, rb, sa, sb, last;
        bit rec_a, rec_b;
        a = it.endpoint_a;
        b = it.endpoint_b;
        s = it.edge_slot;
        r.status = etwa_pkg::ST_OK;
        r.new_index = '0;
        case (etwa_pkg::cmd_t'(it.cmd))
            etwa_pkg::CMD_ADD_EDGE:
            begin
                rec_a = a < n_verts;
                rec_b = b < n_verts && b != a;
                if (n_edges >= etwa_pkg::MAX_EDGES)
                    r.status = etwa_pkg::ST_EDGE_FULL;
                else if ((rec_a && inc_len[a] >= etwa_pkg::MAX_DEGREE) ||
                         (rec_b && inc_len[b] >= etwa_pkg::MAX_DEGREE))
                    r.status = etwa_pkg::ST_ADJ_FULL;
                else
                begin
                    pair_tab[n_edges] = {it.endpoint_a, it.endpoint_b};
                    if (rec_a)
                    begin
                        inc_tab[a*etwa_pkg::MAX_DEGREE+inc_len[a]] = etwa_pkg::EW'(n_edges);
                        inc_len[a]++;
                    end
                    if (rec_b)
                    begin
                        inc_tab[b*etwa_pkg::MAX_DEGREE+inc_len[b]] = etwa_pkg::EW'(n_edges);
                        inc_len[b]++;
                    end
                    r.new_index = etwa_pkg::NIW'(n_edges);
                    n_edges++;
                end
            end
            etwa_pkg::CMD_REM_EDGE:
            begin
                if (s >= n_edges)
                    r.status = etwa_pkg::ST_RANGE;
                else
                begin
                    ra = pair_tab[s][31:16];
                    rb = pair_tab[s][15:0];
                    last = n_edges - 1;
                    if (ra < n_verts)
                        drop_index(ra, s);
                    if (rb < n_verts && rb != ra)
                        drop_index(rb, s);
                    if (s != last)
                    begin
                        sa = pair_tab[last][31:16];
                        sb = pair_tab[last][15:0];
                        pair_tab[s] = pair_tab[last];
                        if (sa < n_verts)
                            move_index(sa, last, s);
                        if (sb < n_verts && sb != sa)
                            move_index(sb, last, s);
                    end
                    n_edges = last;
                end
            end
            etwa_pkg::CMD_ADD_VTX:
            begin
                if (n_verts >= etwa_pkg::MAX_VERTICES)
                    r.status = etwa_pkg::ST_VTX_FULL;
                else
                begin
                    r.new_index = etwa_pkg::NIW'(n_verts);
                    inc_len[n_verts] = 0;
                    n_verts++;
                end
            end
            default:
            begin
                n_edges = 0;
                n_verts = 0;
                foreach (inc_len[i])
                    inc_len[i] = 0;
            end
        endcase
        r.edge_total = etwa_pkg::ETW'(n_edges);
        r.vertex_total = etwa_pkg::VTW'(n_verts);
        return r;
    endfunction

    function automatic row_t mk(etwa_pkg::cmd_t c, int a, int b, int s, bit chk = 0,
                                etwa_pkg::status_t st = etwa_pkg::ST_OK,
                                int et = 0, int vt = 0, int ni = 0);
        row_t w;
        w.it = '{cmd: c, endpoint_a: etwa_pkg::EPW'(a), endpoint_b: etwa_pkg::EPW'(b),
                 edge_slot: etwa_pkg::SLOTW'(s)};
        w.chk = chk;
        w.res = '{status: st, edge_total: etwa_pkg::ETW'(et),
                  vertex_total: etwa_pkg::VTW'(vt), new_index: etwa_pkg::NIW'(ni)};
        return w;
    endfunction

    // accept side: update the mirror and queue what should come out
    always @(posedge clk)
    begin
        row_t              w;
        etwa_pkg::result_t r;
        if (rst_n && in_valid && !in_stall)
        begin
            w = sent_q.pop_front();
            r = apply_command(w.it);
            want_q.insert(want_q.size(), w.chk ? w.res : r);
            n_taken++;
        end
    end

    always @(posedge clk)
    begin
        etwa_pkg::result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            n_seen++;
            status_seen[status]++;
            if (want_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item: status %0d edges %0d", status,
                             edge_total);
            end
            else
            begin
                e = want_q.pop_front();
                if (status !== e.status || edge_total !== e.edge_total ||
                    vertex_total !== e.vertex_total || new_index !== e.new_index)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch at item %0d: exp st %0d et %0d vt %0d ni %0d,",
                                  " got st %0d et %0d vt %0d ni %0d"},
                                 n_seen, e.status, e.edge_total, e.vertex_total,
                                 e.new_index, status, edge_total, vertex_total,
                                 new_index);
                end
            end
        end
    end

    // result side back-pressure
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_req)
            begin
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                long_req = 1'b0;
                out_stall <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > RUN_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send(row_t w);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        sent_q.insert(sent_q.size(), w);
        in_valid   <= 1'b1;
        cmd        <= w.it.cmd;
        endpoint_a <= w.it.endpoint_a;
        endpoint_b <= w.it.endpoint_b;
        edge_slot  <= w.it.edge_slot;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (want_q.size() != 0 || sent_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic row_t random_row();
        int pick, hi;
        pick = $urandom_range(0, 99);
        hi = n_verts + 2;
        if (pick < 12)
            return mk(etwa_pkg::CMD_ADD_VTX, $urandom, $urandom, $urandom);
        else if (pick < 55)
            return mk(etwa_pkg::CMD_ADD_EDGE, $urandom_range(0, hi), $urandom_range(0, hi),
                      $urandom);
        else if (pick < 88)
            return mk(etwa_pkg::CMD_REM_EDGE, $urandom, $urandom,
                      $urandom_range(0, n_edges));
        else if (pick < 97)
            return mk(etwa_pkg::cmd_t'($urandom_range(0, 2)), $urandom, $urandom, $urandom);
        return mk(etwa_pkg::CMD_CLEAR, $urandom, $urandom, $urandom);
    endfunction

    initial
    begin
        in_valid   = 1'b0;
        cmd        = etwa_pkg::CMD_CLEAR;
        endpoint_a = '0;
        endpoint_b = '0;
        edge_slot  = '0;
        rst_n      = 1'b0;
        idle_on    = 1'b1;
        long_req   = 1'b0;
        mismatches = 0;
        n_taken = 0;
        n_seen = 0;
        cycles = 0;
        n_edges = 0;
        n_verts = 0;
        foreach (inc_len[i])
            inc_len[i] = 0;
        foreach (status_seen[i])
            status_seen[i] = 0;

        dir_tab.insert(dir_tab.size(),
            mk(etwa_pkg::CMD_ADD_VTX, 0, 0, 0, 1, etwa_pkg::ST_OK, 0, 1, 0));
        dir_tab.insert(dir_tab.size(),
            mk(etwa_pkg::CMD_ADD_VTX, 0, 0, 0, 1, etwa_pkg::ST_OK, 0, 2, 1));
        dir_tab.insert(dir_tab.size(),
            mk(etwa_pkg::CMD_REM_EDGE, 0, 0, 0, 1, etwa_pkg::ST_RANGE, 0, 2, 0));
        dir_tab.insert(dir_tab.size(),
            mk(etwa_pkg::CMD_ADD_EDGE, 0, 1, 0, 1, etwa_pkg::ST_OK, 1, 2, 0));
        // self loop goes into one list only
        dir_tab.insert(dir_tab.size(),
            mk(etwa_pkg::CMD_ADD_EDGE, 1, 1, 0, 1, etwa_pkg::ST_OK, 2, 2, 1));
        dir_tab.insert(dir_tab.size(),
            mk(etwa_pkg::CMD_ADD_EDGE, 0, 16'hffff, 0, 1, etwa_pkg::ST_OK, 3, 2, 2));
        dir_tab.insert(dir_tab.size(),
            mk(etwa_pkg::CMD_ADD_EDGE, 16'hffff, 16'hffff, 16'h3ff));
        dir_tab.insert(dir_tab.size(), mk(etwa_pkg::CMD_REM_EDGE, 16'hffff, 16'hffff, 0));
        dir_tab.insert(dir_tab.size(),
            mk(etwa_pkg::CMD_REM_EDGE, 0, 0, 1023, 1, etwa_pkg::ST_RANGE, 3, 2, 0));
        dir_tab.insert(dir_tab.size(),
            mk(etwa_pkg::CMD_ADD_VTX, 0, 0, 0, 1, etwa_pkg::ST_OK, 3, 3, 2));
        dir_tab.insert(dir_tab.size(), mk(etwa_pkg::CMD_ADD_EDGE, 2, 0, 0));
        dir_tab.insert(dir_tab.size(), mk(etwa_pkg::CMD_REM_EDGE, 0, 0, 3));
        dir_tab.insert(dir_tab.size(), mk(etwa_pkg::CMD_ADD_EDGE, 16'h8000, 16'h7fff, 16'h2aa));
        dir_tab.insert(dir_tab.size(), mk(etwa_pkg::CMD_REM_EDGE, 0, 0, 1));
        dir_tab.insert(dir_tab.size(),
            mk(etwa_pkg::CMD_CLEAR, 16'h5555, 16'haaaa, 16'h155, 1, etwa_pkg::ST_OK, 0, 0, 0));
        // edge recorded before its vertices exist, then removed
        dir_tab.insert(dir_tab.size(),
            mk(etwa_pkg::CMD_ADD_EDGE, 0, 1, 0, 1, etwa_pkg::ST_OK, 1, 0, 0));
        dir_tab.insert(dir_tab.size(),
            mk(etwa_pkg::CMD_ADD_VTX, 0, 0, 0, 1, etwa_pkg::ST_OK, 1, 1, 0));
        dir_tab.insert(dir_tab.size(),
            mk(etwa_pkg::CMD_ADD_VTX, 0, 0, 0, 1, etwa_pkg::ST_OK, 1, 2, 1));
        dir_tab.insert(dir_tab.size(), mk(etwa_pkg::CMD_ADD_EDGE, 1, 0, 0));
        dir_tab.insert(dir_tab.size(), mk(etwa_pkg::CMD_REM_EDGE, 0, 0, 0));
        dir_tab.insert(dir_tab.size(), mk(etwa_pkg::CMD_REM_EDGE, 0, 0, 0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
            send(dir_tab[i]);
        drain();

        // fill the list of vertex 0 until it refuses
        send(mk(etwa_pkg::CMD_CLEAR, 0, 0, 0));
        send(mk(etwa_pkg::CMD_ADD_VTX, 0, 0, 0));
        send(mk(etwa_pkg::CMD_ADD_VTX, 0, 0, 0));
        for (int i = 0; i < 18; i++)
            send(mk(etwa_pkg::CMD_ADD_EDGE, 0, (i % 2) ? 0 : 1, 0));
        send(mk(etwa_pkg::CMD_ADD_EDGE, 1, 0, 0));
        for (int i = 0; i < 6; i++)
            send(mk(etwa_pkg::CMD_REM_EDGE, 0, 0, $urandom_range(0, 16)));
        drain();

        // long result-side stall while items keep coming
        long_req = 1'b1;
        for (int i = 0; i < 12; i++)
            send(random_row());
        drain();

        // vertex and edge tables to their limits
        send(mk(etwa_pkg::CMD_CLEAR, 0, 0, 0));
        for (int i = 0; i <= etwa_pkg::MAX_VERTICES; i++)
            send(mk(etwa_pkg::CMD_ADD_VTX, $urandom, $urandom, $urandom));
        for (int i = 0; i < etwa_pkg::MAX_EDGES + 2; i++)
            send(mk(etwa_pkg::CMD_ADD_EDGE, $urandom_range(etwa_pkg::MAX_VERTICES, 65535),
                    (i % 64 == 0) ? $urandom_range(0, 255) : $urandom, 0));
        for (int i = 0; i < 8; i++)
            send(mk(etwa_pkg::CMD_REM_EDGE, $urandom, $urandom, $urandom));
        drain();

        send(mk(etwa_pkg::CMD_CLEAR, 0, 0, 0));
        for (int i = 0; i < 60; i++)
        begin
            if (i == 45)
                idle_on = 1'b0;
            send(random_row());
        end
        drain();

        $display("covered %0d items in, %0d results compared, lists, vertices and edges full",
                 n_taken, n_seen);
        $display("status counts ok %0d range %0d edge full %0d adj full %0d vtx full %0d",
                 status_seen[etwa_pkg::ST_OK], status_seen[etwa_pkg::ST_RANGE],
                 status_seen[etwa_pkg::ST_EDGE_FULL], status_seen[etwa_pkg::ST_ADJ_FULL],
                 status_seen[etwa_pkg::ST_VTX_FULL]);
        if (mismatches == 0 && want_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
